[rtl/ddft_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddft_pkg : shared types and constants of the direct DFT block
// Sizes, the sample and control types, the sequencer states and the Q1.15
// twiddle table, which is built once at elaboration.
// ----------------------------------------------------------------------------
package ddft_pkg;

  // Frame length; the inverse scaling is an arithmetic shift, so keep it a
  // power of two
  localparam int POINTS = 64;
  localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CNT_W  = $clog2(POINTS + 1);

  localparam int DATA_W = 32;
  localparam int TW_W   = 16;
  localparam int PROD_W = DATA_W + TW_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int ACC_W  = PAIR_W + IDX_W;
  localparam int FRAC_W = 15;

  localparam longint PI4_Q30 = 64'sd843314857;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  // Ring control: shift the chain, feed it from its head, or feed zeros
  typedef struct packed {
    logic en;
    logic rotate;
    logic zero;
  } shift_t;

  // One product term issued to the multiply-accumulate pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             bin_last;
    logic [IDX_W-1:0] p;
  } term_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PAD,
    ST_COMPUTE
  } state_t;

  typedef logic [2*TW_W-1:0] tw_rom_t [POINTS];

  // Build cos and sin of 2*pi*p/POINTS: first-octant Taylor series in Q30,
  // rounded to Q1.15, unfolded by octant symmetry. Entry is {cos, sin}.
  function automatic tw_rom_t tw_build();
    tw_rom_t rom;
    int      r8;
    int      oct;
    longint  rem, x, x2, x3, x4, x5, x6, x7, x8;
    longint  s0, c0, s, c;
    for (int p = 0; p < POINTS; p++) begin
      r8  = 8 * p;
      oct = (r8 / POINTS) % 8;
      rem = longint'(r8 % POINTS);
      if ((oct % 2) == 1) begin
        rem = longint'(POINTS) - rem;
      end
      x  = (PI4_Q30 * rem + longint'(POINTS / 2)) / POINTS;
      x2 = (x * x) >>> 30;
      x3 = (x2 * x) >>> 30;
      x4 = (x3 * x) >>> 30;
      x5 = (x4 * x) >>> 30;
      x6 = (x5 * x) >>> 30;
      x7 = (x6 * x) >>> 30;
      x8 = (x7 * x) >>> 30;
      s0 = (x - x3 / 6 + x5 / 120 - x7 / 5040 + 16384) >>> 15;
      c0 = (ONE_Q30 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320 + 16384) >>> 15;
      if (s0 > 32767) begin
        s0 = 32767;
      end
      if (c0 > 32767) begin
        c0 = 32767;
      end
      case (oct)
        0:       begin s = s0;  c = c0;  end
        1:       begin s = c0;  c = s0;  end
        2:       begin s = c0;  c = -s0; end
        3:       begin s = s0;  c = -c0; end
        4:       begin s = -s0; c = -c0; end
        5:       begin s = -c0; c = -s0; end
        6:       begin s = -c0; c = s0;  end
        default: begin s = -s0; c = c0;  end
      endcase
      rom[p] = {c[TW_W-1:0], s[TW_W-1:0]};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = tw_build();

endpackage
`default_nettype wire

[rtl/ddft_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddft_ifs : sample and bin channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ddft_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddft_pkg::DATA_W-1:0] sample_real;
  logic signed [ddft_pkg::DATA_W-1:0] sample_imag;
  logic                               frame_last;

  modport source (output valid, output sample_real, output sample_imag,
                  output frame_last, input ready);
  modport sink   (input valid, input sample_real, input sample_imag,
                  input frame_last, output ready);
endinterface

interface ddft_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddft_pkg::DATA_W-1:0] bin_real;
  logic signed [ddft_pkg::DATA_W-1:0] bin_imag;
  logic                               bin_last;

  modport source (output valid, output bin_real, output bin_imag,
                  output bin_last, input ready);
  modport sink   (input valid, input bin_real, input bin_imag,
                  input bin_last, output ready);
endinterface
`default_nettype wire

[rtl/ddft_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddft_cell : one element of the frame ring
// Holds one complex sample and takes its neighbour's value on each shift.
// ----------------------------------------------------------------------------
module ddft_cell (
  input  wire                  clk,
  input  wire                  en,
  input  wire ddft_pkg::cplx_t d,
  output ddft_pkg::cplx_t      q
);
  import ddft_pkg::*;

  cplx_t val_r;

  // Take the neighbour's sample on a shift, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule
`default_nettype wire

[rtl/ddft_chain.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddft_chain : ring of sample cells
// Samples enter at the tail and move one cell towards the head per shift.
// While computing, the head feeds back to the tail so the frame circulates.
// ----------------------------------------------------------------------------
module ddft_chain (
  input  wire                   clk,
  input  wire ddft_pkg::shift_t shift,
  input  wire ddft_pkg::cplx_t  sample,
  output ddft_pkg::cplx_t       head
);
  import ddft_pkg::*;

  cplx_t link [POINTS+1];

  // Pick the tail input: circulate, pad with zero, or load a new beat
  always_comb begin
    if (shift.rotate) begin
      link[POINTS] = link[0];
    end else if (shift.zero) begin
      link[POINTS] = '0;
    end else begin
      link[POINTS] = sample;
    end
  end

  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    ddft_cell u_cell (
      .clk (clk),
      .en  (shift.en),
      .d   (link[i+1]),
      .q   (link[i])
    );
  end

  assign head = link[0];

endmodule
`default_nettype wire

[rtl/ddft_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddft_mac : complex multiply-accumulate and bin output
// Products, pair sums, 55-bit exact accumulation, rounding, inverse scaling
// and saturation, then the output register. Every stage advances together
// whenever the output register is free or being drained.
// ----------------------------------------------------------------------------
module ddft_mac (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire ddft_pkg::cplx_t head,
  input  wire ddft_pkg::term_t term,
  input  wire                  inv,
  output logic                 adv,
  ddft_out_if.source           out_bus
);
  import ddft_pkg::*;

  localparam int Q_W = ACC_W + 1 - FRAC_W;

  term_t                    t1_r, t2_r, t3_r;
  logic signed [TW_W-1:0]   tw_c, tw_s;
  logic signed [PROD_W-1:0] p_rc_r, p_is_r, p_rs_r, p_ic_r;
  logic signed [PAIR_W-1:0] pair_re_nxt, pair_im_nxt, pair_re_r, pair_im_r;
  logic signed [ACC_W-1:0]  acc_re_nxt, acc_im_nxt, acc_re_r, acc_im_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] bin_re_r, bin_im_r;
  logic                     bin_last_r;

  // Round Q30 sum to Q15, scale for inverse, saturate to 32 bits
  function automatic logic [DATA_W-1:0] finish(input logic signed [ACC_W-1:0] acc,
                                               input logic inv_mode);
    logic signed [ACC_W:0]        rnd;
    logic signed [Q_W-1:0]        q15;
    logic signed [Q_W-1:0]        scl;
    logic [Q_W-DATA_W:0]          top;
    rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_W - 1));
    q15 = rnd[ACC_W:FRAC_W];
    scl = inv_mode ? (q15 >>> IDX_W) : q15;
    top = scl[Q_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return scl[DATA_W-1:0];
    end else if (scl[Q_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  assign adv  = !out_valid_r || out_bus.ready;
  assign tw_c = TW_ROM[term.p][2*TW_W-1:TW_W];
  assign tw_s = TW_ROM[term.p][TW_W-1:0];

  // Combine products by twiddle sign and accumulate
  always_comb begin
    if (inv) begin
      pair_re_nxt = PAIR_W'(p_rc_r) - PAIR_W'(p_is_r);
      pair_im_nxt = PAIR_W'(p_rs_r) + PAIR_W'(p_ic_r);
    end else begin
      pair_re_nxt = PAIR_W'(p_rc_r) + PAIR_W'(p_is_r);
      pair_im_nxt = PAIR_W'(p_ic_r) - PAIR_W'(p_rs_r);
    end
    acc_re_nxt = (t2_r.first ? '0 : acc_re_r) + ACC_W'(pair_re_r);
    acc_im_nxt = (t2_r.first ? '0 : acc_im_r) + ACC_W'(pair_im_r);
  end

  // Advance the control flags of each stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r        <= '0;
      t2_r        <= '0;
      t3_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      t1_r        <= term;
      t2_r        <= t1_r;
      t3_r        <= t2_r;
      out_valid_r <= t3_r.valid && t3_r.last;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      p_rc_r    <= head.re * tw_c;
      p_is_r    <= head.im * tw_s;
      p_rs_r    <= head.re * tw_s;
      p_ic_r    <= head.im * tw_c;
      pair_re_r <= pair_re_nxt;
      pair_im_r <= pair_im_nxt;
      if (t2_r.valid) begin
        acc_re_r <= acc_re_nxt;
        acc_im_r <= acc_im_nxt;
      end
      if (t3_r.valid && t3_r.last) begin
        bin_re_r   <= finish(acc_re_r, inv);
        bin_im_r   <= finish(acc_im_r, inv);
        bin_last_r <= t3_r.bin_last;
      end
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.bin_real = bin_re_r;
  assign out_bus.bin_imag = bin_im_r;
  assign out_bus.bin_last = bin_last_r;

  // A completed bin lands in the output register on the next advance
  a_bin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && t3_r.valid && t3_r.last) |=> out_valid_r)
    else $error("completed bin not presented");

endmodule
`default_nettype wire

[rtl/direct_dft_forward_inverse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// direct_dft_forward_inverse : direct forward/inverse DFT over a sample frame
// A short frame is padded with zeros after its closing beat; each bin then
//   passes the product, pair, accumulate and output registers in turn.
// Bins are computed one at a time by the single multiply-accumulate unit fed
//   from the ring; a new frame is taken only once the bin sweep has ended.
// Reset: rst_n synchronous, clears the sequencer, pipeline flags and mode.
// ----------------------------------------------------------------------------
module direct_dft_forward_inverse (
  input  wire        clk,
  input  wire        rst_n,
  ddft_in_if.sink    in_bus,
  ddft_out_if.source out_bus,
  input  wire        cfg_we,
  input  wire        cfg_wdata
);
  import ddft_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [IDX_W-1:0] n_r, n_nxt, k_r, k_nxt, p_r, p_nxt;
  logic [IDX_W:0]   p_sum;
  logic             inv_r;
  logic             in_acc;
  logic             adv;
  logic             n_end, k_end;
  shift_t           shift;
  term_t            term;
  cplx_t            sample, head;

  assign sample.re = in_bus.sample_real;
  assign sample.im = in_bus.sample_imag;
  assign in_bus.ready = (state_r == ST_LOAD);
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign n_end   = (n_r == IDX_W'(POINTS - 1));
  assign k_end   = (k_r == IDX_W'(POINTS - 1));
  assign p_sum   = {1'b0, p_r} + {1'b0, k_r};

  // Hold the transform direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (cfg_we) begin
      inv_r <= cfg_wdata;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      k_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      p_r     <= p_nxt;
    end
  end

  // Load, pad short frames with zeros, then sweep bins and terms
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    p_nxt        = p_r;
    shift        = '0;
    term         = '0;
    term.first   = (n_r == '0);
    term.last    = n_end;
    term.bin_last = k_end;
    term.p       = p_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          shift.en = 1'b1;
          cnt_nxt  = cnt_inc;
          if (cnt_inc == CNT_W'(POINTS)) begin
            cnt_nxt   = '0;
            state_nxt = ST_COMPUTE;
          end else if (in_bus.frame_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift.en   = 1'b1;
        shift.zero = 1'b1;
        cnt_nxt    = cnt_inc;
        if (cnt_inc == CNT_W'(POINTS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_COMPUTE;
        end
      end
      ST_COMPUTE: begin
        term.valid   = 1'b1;
        shift.rotate = 1'b1;
        shift.en     = adv;
        if (adv) begin
          if (n_end) begin
            n_nxt = '0;
            p_nxt = '0;
            if (k_end) begin
              k_nxt     = '0;
              state_nxt = ST_LOAD;
            end else begin
              k_nxt = k_r + IDX_W'(1);
            end
          end else begin
            n_nxt = n_r + IDX_W'(1);
            if (p_sum >= (IDX_W+1)'(POINTS)) begin
              p_nxt = IDX_W'(p_sum - (IDX_W+1)'(POINTS));
            end else begin
              p_nxt = p_sum[IDX_W-1:0];
            end
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  ddft_chain u_chain (
    .clk    (clk),
    .shift  (shift),
    .sample (sample),
    .head   (head)
  );

  ddft_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .term    (term),
    .inv     (inv_r),
    .adv     (adv),
    .out_bus (out_bus)
  );

  // A flagged beat always closes the frame
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus.frame_last) |=> (state_r != ST_LOAD))
    else $error("frame_last beat did not close the frame");

  // The final term of the final bin returns the block to loading
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPUTE && adv && n_end && k_end) |=> (state_r == ST_LOAD))
    else $error("bin sweep did not end");

  // Terms are issued only while computing, and only the ring is rotated then
  a_no_load_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPUTE) |-> (!in_acc && shift.rotate))
    else $error("beat taken during compute");

endmodule
`default_nettype wire
